### rtl/timestamp_argument_validator_top_macros.svh
// Assertion macros for the timestamp argument validator checker.
// Used by tav_checker only; no other dependencies.
`ifndef TIMESTAMP_ARGUMENT_VALIDATOR_TOP_MACROS_SVH
`define TIMESTAMP_ARGUMENT_VALIDATOR_TOP_MACROS_SVH

// Concurrent assertion, disabled while reset is asserted.
`define TAV_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define TAV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/tav_pkg.sv
// Shared types, codes and character helpers for the timestamp argument validator.
// No dependencies; imported by every RTL module of the block.
package tav_pkg;

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_POINT = 8'h2E;

    // Unit codes, ordered so that a valid token string strictly decreases.
    localparam logic [2:0] UNIT_US    = 3'd0;
    localparam logic [2:0] UNIT_SEC   = 3'd1;
    localparam logic [2:0] UNIT_MIN   = 3'd2;
    localparam logic [2:0] UNIT_HOUR  = 3'd3;
    localparam logic [2:0] UNIT_DAY   = 3'd4;
    localparam logic [2:0] UNIT_MONTH = 3'd5;
    localparam logic [2:0] UNIT_YEAR  = 3'd6;
    localparam logic [2:0] UNIT_NONE  = 3'd7;

    localparam logic [1:0] FORM_NONE  = 2'd0;
    localparam logic [1:0] FORM_TOKEN = 2'd1;
    localparam logic [1:0] FORM_RAW   = 2'd2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SECONDS_LIMIT  = 2'd0,
        CFG_AMOUNT_LIMIT   = 2'd1,
        CFG_FRACTION_LIMIT = 2'd2,
        CFG_TOKEN_LIMIT    = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        RAW_START    = 2'd0,
        RAW_SECONDS  = 2'd1,
        RAW_POINT    = 2'd2,
        RAW_FRACTION = 2'd3
    } raw_phase_t;

    typedef enum logic {
        TOK_DIGIT  = 1'b0,
        TOK_AMOUNT = 1'b1
    } tok_phase_t;

    // Per-character control from the top level to both checkers.
    typedef struct packed {
        logic       feed;
        logic       clear;
        logic [7:0] ch;
    } tav_step_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    // Case-insensitive unit letter decode.
    function automatic logic [2:0] unit_of(input logic [7:0] c);
        logic [7:0] lc;
        logic [2:0] u;
        lc = ((c >= 8'h41) && (c <= 8'h5A)) ? (c | 8'h20) : c;
        case (lc)
            8'h79:   u = UNIT_YEAR;
            8'h64:   u = UNIT_DAY;
            8'h68:   u = UNIT_HOUR;
            8'h6D:   u = UNIT_MIN;
            8'h73:   u = UNIT_SEC;
            8'h75:   u = UNIT_US;
            default: u = UNIT_NONE;
        endcase
        return u;
    endfunction

endpackage

### rtl/tav_raw_check.sv
// Raw seconds form checker: digits within a limit, optional point and fraction.
// Depends on tav_pkg.
module tav_raw_check
    import tav_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  tav_step_t   step,
    input  logic [31:0] seconds_limit,
    input  logic [3:0]  fraction_limit,
    output logic        raw_ok
);

    raw_phase_t  phase_reg, phase_next;
    logic [31:0] value_reg, value_next;
    logic [3:0]  frac_reg, frac_next;
    logic        failed_reg, failed_next;

    logic        dig;
    logic [3:0]  digit_val;
    logic [35:0] acc;
    logic [4:0]  frac_acc;

    assign dig       = is_digit(step.ch);
    assign digit_val = step.ch[3:0];
    assign acc       = {1'b0, value_reg, 3'b000} + {3'b000, value_reg, 1'b0}
                     + {32'd0, digit_val};
    assign frac_acc  = (phase_reg == RAW_POINT) ? 5'd1 : ({1'b0, frac_reg} + 5'd1);

    // Next phase and failure flag
    always_comb begin
        phase_next  = phase_reg;
        failed_next = failed_reg;
        if (step.clear) begin
            phase_next  = RAW_START;
            failed_next = 1'b0;
        end else if (step.feed && !failed_reg) begin
            unique case (phase_reg)
                RAW_START: begin
                    if (!dig || ({28'd0, digit_val} > seconds_limit)) begin
                        failed_next = 1'b1;
                    end else begin
                        phase_next = RAW_SECONDS;
                    end
                end
                RAW_SECONDS: begin
                    if (step.ch == CHAR_POINT) begin
                        phase_next = RAW_POINT;
                    end else if (!dig || (acc > {4'd0, seconds_limit})) begin
                        failed_next = 1'b1;
                    end
                end
                RAW_POINT, RAW_FRACTION: begin
                    if (!dig || (frac_acc > {1'b0, fraction_limit})) begin
                        failed_next = 1'b1;
                    end else begin
                        phase_next = RAW_FRACTION;
                    end
                end
                default: phase_next = RAW_START;
            endcase
        end
    end

    // Value and fraction count updates
    always_comb begin
        value_next = value_reg;
        frac_next  = frac_reg;
        if (step.clear) begin
            value_next = '0;
            frac_next  = '0;
        end else if (step.feed && !failed_next) begin
            unique case (phase_reg)
                RAW_START:               value_next = {28'd0, digit_val};
                RAW_SECONDS: begin
                    if (step.ch != CHAR_POINT) begin
                        value_next = acc[31:0];
                    end
                end
                RAW_POINT, RAW_FRACTION: frac_next  = frac_acc[3:0];
                default:                 value_next = value_reg;
            endcase
        end
    end

    assign raw_ok = !failed_reg && ((phase_reg == RAW_SECONDS) || (phase_reg == RAW_FRACTION));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= RAW_START;
            value_reg  <= '0;
            frac_reg   <= '0;
            failed_reg <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            value_reg  <= value_next;
            frac_reg   <= frac_next;
            failed_reg <= failed_next;
        end
    end

endmodule

### rtl/tav_token_check.sv
// Unit token form checker: amount/unit tokens with strictly decreasing units.
// Depends on tav_pkg.
module tav_token_check
    import tav_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  tav_step_t   step,
    input  logic [31:0] amount_limit,
    input  logic [2:0]  token_limit,
    output logic        tok_ok
);

    tok_phase_t  phase_reg, phase_next;
    logic [31:0] amount_reg, amount_next;
    logic [2:0]  count_reg, count_next;
    logic [2:0]  prev_unit_reg, prev_unit_next;
    logic [2:0]  cur_unit_reg, cur_unit_next;
    logic        failed_reg, failed_next;

    logic        dig;
    logic        alpha;
    logic [3:0]  digit_val;
    logic [35:0] acc;
    logic [2:0]  unit;
    logic [2:0]  pending;

    assign dig       = is_digit(step.ch);
    assign alpha     = is_alpha(step.ch);
    assign digit_val = step.ch[3:0];
    assign unit      = unit_of(step.ch);
    assign acc       = {1'b0, amount_reg, 3'b000} + {3'b000, amount_reg, 1'b0}
                     + {32'd0, digit_val};
    // 'm' right before 'd' is month
    assign pending   = ((cur_unit_reg == UNIT_MIN) && (unit == UNIT_DAY)) ? UNIT_MONTH
                                                                          : cur_unit_reg;

    // Next phase and failure flag
    always_comb begin
        phase_next  = phase_reg;
        failed_next = failed_reg;
        if (step.clear) begin
            phase_next  = TOK_DIGIT;
            failed_next = 1'b0;
        end else if (step.feed && !failed_reg) begin
            unique case (phase_reg)
                TOK_DIGIT: begin
                    if (!dig || (count_reg >= token_limit)
                        || ({28'd0, digit_val} > amount_limit)) begin
                        failed_next = 1'b1;
                    end else begin
                        phase_next = TOK_AMOUNT;
                    end
                end
                TOK_AMOUNT: begin
                    if (alpha) begin
                        if ((unit == UNIT_NONE)
                            || ((count_reg >= 3'd2) && (prev_unit_reg <= pending))) begin
                            failed_next = 1'b1;
                        end else begin
                            phase_next = TOK_DIGIT;
                        end
                    end else if (!dig || (acc > {4'd0, amount_limit})) begin
                        failed_next = 1'b1;
                    end
                end
                default: phase_next = TOK_DIGIT;
            endcase
        end
    end

    // Amount, count and unit history updates
    always_comb begin
        amount_next    = amount_reg;
        count_next     = count_reg;
        prev_unit_next = prev_unit_reg;
        cur_unit_next  = cur_unit_reg;
        if (step.clear) begin
            amount_next    = '0;
            count_next     = '0;
            prev_unit_next = UNIT_US;
            cur_unit_next  = UNIT_US;
        end else if (step.feed && !failed_next) begin
            unique case (phase_reg)
                TOK_DIGIT:  amount_next = {28'd0, digit_val};
                TOK_AMOUNT: begin
                    if (alpha) begin
                        if (count_reg >= 3'd1) begin
                            prev_unit_next = pending;
                        end
                        cur_unit_next = unit;
                        count_next    = count_reg + 3'd1;
                    end else begin
                        amount_next = acc[31:0];
                    end
                end
                default: amount_next = amount_reg;
            endcase
        end
    end

    assign tok_ok = !failed_reg && (phase_reg == TOK_DIGIT) && (count_reg != 3'd0)
                  && !((count_reg >= 3'd2) && (prev_unit_reg <= cur_unit_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= TOK_DIGIT;
            amount_reg    <= '0;
            count_reg     <= '0;
            prev_unit_reg <= UNIT_US;
            cur_unit_reg  <= UNIT_US;
            failed_reg    <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            amount_reg    <= amount_next;
            count_reg     <= count_next;
            prev_unit_reg <= prev_unit_next;
            cur_unit_reg  <= cur_unit_next;
            failed_reg    <= failed_next;
        end
    end

endmodule

### rtl/timestamp_argument_validator_top.sv
// Top level of the timestamp argument validator: input register, leading plus
// handling, config registers and result register. Depends on tav_pkg,
// tav_raw_check and tav_token_check.
//
//  channel | ports                            | contents
//  --------+----------------------------------+------------------------------------
//  input   | s_tvalid s_tready s_tdata s_tlast | tdata[7:0] character, tlast end
//  result  | m_tvalid m_tready m_tdata m_tuser | tdata is_valid, has_plus; tuser kind
//  config  | cfg_wr_en cfg_index cfg_data      | 0 seconds, 1 amount, 2 fraction, 3 tokens
//
// One character per cycle while s_tready is high. A transaction is registered
// on accept and the checkers update from that register on the next edge; an end
// transaction waits there for a free result register and is loaded into m_* as
// the checkers clear. s_tready drops only in reset or while an end transaction waits.
// Synchronous active-low reset clears all control and checker state.
module timestamp_argument_validator_top
    import tav_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] character
    input  logic                   s_tlast,   // end_of_string
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,   // [0] is_valid, [1] has_plus, [7:2] zero
    output logic [1:0]             m_tuser,   // [1:0] form_kind
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [31:0] seconds_limit_reg;
    logic [31:0] amount_limit_reg;
    logic [3:0]  fraction_limit_reg;
    logic [2:0]  token_limit_reg;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_char_reg;
    logic        in_last_reg;

    logic        seen_first_reg, seen_first_next;
    logic        plus_reg, plus_next;

    logic        out_valid_reg, out_valid_next;
    logic        out_is_valid_reg, out_is_valid_next;
    logic        out_plus_reg, out_plus_next;
    logic [1:0]  out_kind_reg, out_kind_next;

    logic        proc_go;
    logic        lead_plus;
    logic        raw_ok;
    logic        tok_ok;
    logic [1:0]  kind;
    tav_step_t   step;

    assign proc_go   = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready  = aresetn && (!in_valid_reg || proc_go);
    assign lead_plus = !seen_first_reg && (in_char_reg == CHAR_PLUS);

    assign step.feed  = proc_go && !in_last_reg && !lead_plus;
    assign step.clear = proc_go && in_last_reg;
    assign step.ch    = in_char_reg;

    tav_raw_check u_raw (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (step),
        .seconds_limit  (seconds_limit_reg),
        .fraction_limit (fraction_limit_reg),
        .raw_ok         (raw_ok)
    );

    tav_token_check u_token (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .amount_limit (amount_limit_reg),
        .token_limit  (token_limit_reg),
        .tok_ok       (tok_ok)
    );

    assign kind = tok_ok ? FORM_TOKEN : (raw_ok ? FORM_RAW : FORM_NONE);

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end else if (proc_go) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        seen_first_next = seen_first_reg;
        plus_next       = plus_reg;
        if (step.clear) begin
            seen_first_next = 1'b0;
            plus_next       = 1'b0;
        end else if (proc_go) begin
            seen_first_next = 1'b1;
            if (lead_plus) begin
                plus_next = 1'b1;
            end
        end
    end

    always_comb begin
        out_valid_next    = out_valid_reg;
        out_is_valid_next = out_is_valid_reg;
        out_plus_next     = out_plus_reg;
        out_kind_next     = out_kind_reg;
        if (step.clear) begin
            out_valid_next    = 1'b1;
            out_is_valid_next = (kind != FORM_NONE);
            out_plus_next     = plus_reg;
            out_kind_next     = kind;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seconds_limit_reg  <= 32'd2147483647;
            amount_limit_reg   <= 32'd2147483647;
            fraction_limit_reg <= 4'd6;
            token_limit_reg    <= 3'd7;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SECONDS_LIMIT:  seconds_limit_reg  <= cfg_data[31:0];
                CFG_AMOUNT_LIMIT:   amount_limit_reg   <= cfg_data[31:0];
                CFG_FRACTION_LIMIT: fraction_limit_reg <= cfg_data[3:0];
                CFG_TOKEN_LIMIT:    token_limit_reg    <= cfg_data[2:0];
                default:            token_limit_reg    <= token_limit_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            seen_first_reg <= 1'b0;
            plus_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg   <= in_valid_next;
            seen_first_reg <= seen_first_next;
            plus_reg       <= plus_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_tready) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        out_is_valid_reg <= out_is_valid_next;
        out_plus_reg     <= out_plus_next;
        out_kind_reg     <= out_kind_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_plus_reg, out_is_valid_reg};
    assign m_tuser  = out_kind_reg;

endmodule

### rtl/tav_checker.sv
// Port-level assertions for the timestamp argument validator, bound to the top.
// Depends on tav_pkg and timestamp_argument_validator_top_macros.svh.
`include "timestamp_argument_validator_top_macros.svh"

module tav_checker
    import tav_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser
);

    `TAV_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    // is_valid agrees with the reported form
    `TAV_ASSERT(a_valid_matches_kind, aclk, aresetn, m_tvalid |-> ((m_tdata[0] == (m_tuser != FORM_NONE)) && (m_tuser != 2'd3)), "is_valid and form_kind disagree")

    // a fresh result follows an accepted end transaction
    `TAV_ASSERT(a_result_from_end, aclk, aresetn, $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2), "result without end transaction")

    `TAV_ASSERT(a_stall_holds, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "stalled result changed")

endmodule

bind timestamp_argument_validator_top tav_checker u_tav_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### tb/tb_timestamp_argument_validator_top.sv
// Self-checking testbench for timestamp_argument_validator_top: timestamp strings in,
// one verdict per string out, compared with a scanner model or a typed expectation.
// Depends on tav_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_timestamp_argument_validator_top;
    import tav_pkg::*;

    typedef struct packed {
        logic       ok;
        logic [1:0] form;
        logic       plus;
    } verdict_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = '0;     // [7:0] character
    logic                   s_tlast   = 1'b0;   // end_of_string
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [7:0]             m_tdata;            // [0] is_valid, [1] has_plus
    logic [1:0]             m_tuser;            // [1:0] form_kind
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    timestamp_argument_validator_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    // Scanner model: limits and per-string state.
    logic [31:0] lim_seconds, lim_amount;
    logic [3:0]  lim_fraction;
    logic [2:0]  lim_tokens;

    bit          scan_started, scan_plus;
    raw_phase_t  raw_ph;
    logic [31:0] raw_secs;
    logic [3:0]  raw_frac;
    bit          raw_bad;
    tok_phase_t  tok_ph;
    logic [31:0] tok_amt;
    logic [2:0]  tok_cnt, tok_prev, tok_cur;
    bit          tok_bad;

    verdict_t    pending_verdicts[$];
    logic [7:0]  word[$];
    string       probe_text[$];
    bit          probe_typed[$];
    verdict_t    probe_want[$];
    int          mismatches = 0;
    int          accepted = 0;
    int          burst_left = 0;
    int          ready_mode = 0;
    int          ready_left = 0;

    function automatic void clear_scan();
        scan_started = 0;
        scan_plus    = 0;
        raw_ph       = RAW_START;
        raw_secs     = '0;
        raw_frac     = '0;
        raw_bad      = 0;
        tok_ph       = TOK_DIGIT;
        tok_amt      = '0;
        tok_cnt      = '0;
        tok_prev     = '0;
        tok_cur      = '0;
        tok_bad      = 0;
    endfunction

    function automatic logic [2:0] letter_unit(input logic [7:0] c);
        logic [7:0] lc;
        lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        case (lc)
            "y":     return UNIT_YEAR;
            "d":     return UNIT_DAY;
            "h":     return UNIT_HOUR;
            "m":     return UNIT_MIN;
            "s":     return UNIT_SEC;
            "u":     return UNIT_US;
            default: return UNIT_NONE;
        endcase
    endfunction

    function automatic void raw_char(input logic [7:0] c);
        bit          dig;
        logic [63:0] acc;
        dig = (c >= "0" && c <= "9");
        if (raw_bad)
            return;
        case (raw_ph)
            RAW_START: begin
                if (!dig || {60'd0, c[3:0]} > {32'd0, lim_seconds}) begin
                    raw_bad = 1;
                end else begin
                    raw_secs = {28'd0, c[3:0]};
                    raw_ph   = RAW_SECONDS;
                end
            end
            RAW_SECONDS: begin
                if (c == CHAR_POINT) begin
                    raw_ph = RAW_POINT;
                end else if (!dig) begin
                    raw_bad = 1;
                end else begin
                    acc = {32'd0, raw_secs} * 64'd10 + {60'd0, c[3:0]};
                    if (acc > {32'd0, lim_seconds})
                        raw_bad = 1;
                    else
                        raw_secs = acc[31:0];
                end
            end
            default: begin
                if (!dig) begin
                    raw_bad = 1;
                end else begin
                    acc = (raw_ph == RAW_POINT) ? 64'd1 : {60'd0, raw_frac} + 64'd1;
                    if (acc > {60'd0, lim_fraction}) begin
                        raw_bad = 1;
                    end else begin
                        raw_frac = acc[3:0];
                        raw_ph   = RAW_FRACTION;
                    end
                end
            end
        endcase
    endfunction

    function automatic void token_char(input logic [7:0] c);
        bit          dig, alpha;
        logic [63:0] acc;
        logic [2:0]  u, pend;
        dig   = (c >= "0" && c <= "9");
        alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        if (tok_bad)
            return;
        if (tok_ph == TOK_DIGIT) begin
            if (!dig || tok_cnt >= lim_tokens || {28'd0, c[3:0]} > lim_amount) begin
                tok_bad = 1;
            end else begin
                tok_amt = {28'd0, c[3:0]};
                tok_ph  = TOK_AMOUNT;
            end
            return;
        end
        if (alpha) begin
            u = letter_unit(c);
            if (u == UNIT_NONE) begin
                tok_bad = 1;
                return;
            end
            if (tok_cnt >= 3'd1) begin
                // minutes directly ahead of days really meant months
                pend = (tok_cur == UNIT_MIN && u == UNIT_DAY) ? UNIT_MONTH : tok_cur;
                if (tok_cnt >= 3'd2 && tok_prev <= pend) begin
                    tok_bad = 1;
                    return;
                end
                tok_prev = pend;
            end
            tok_cur = u;
            tok_cnt = tok_cnt + 3'd1;
            tok_ph  = TOK_DIGIT;
            return;
        end
        if (!dig) begin
            tok_bad = 1;
            return;
        end
        acc = {32'd0, tok_amt} * 64'd10 + {60'd0, c[3:0]};
        if (acc > {32'd0, lim_amount})
            tok_bad = 1;
        else
            tok_amt = acc[31:0];
    endfunction

    // Returns 1 and the verdict when the item closes a string.
    function automatic bit scan_char(input logic [7:0] c, input bit eos, output verdict_t v);
        bit tok_ok, raw_ok;
        v = '0;
        if (!eos) begin
            if (!scan_started) begin
                scan_started = 1;
                if (c == CHAR_PLUS) begin
                    scan_plus = 1;
                    return 0;
                end
            end
            raw_char(c);
            token_char(c);
            return 0;
        end
        tok_ok = !tok_bad && tok_ph == TOK_DIGIT && tok_cnt != 3'd0;
        if (tok_ok && tok_cnt >= 3'd2 && tok_prev <= tok_cur)
            tok_ok = 0;
        raw_ok = !raw_bad && (raw_ph == RAW_SECONDS || raw_ph == RAW_FRACTION);
        v.form = tok_ok ? FORM_TOKEN : (raw_ok ? FORM_RAW : FORM_NONE);
        v.ok   = (v.form != FORM_NONE);
        v.plus = scan_plus;
        clear_scan();
        return 1;
    endfunction

    // Stimulus builders, all appending to word.
    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            word.push_back(s[i]);
    endfunction

    // Amounts cluster around the limit so overflow is hit from both sides.
    function automatic void push_amount(input logic [31:0] lim);
        logic [63:0] v;
        case ($urandom_range(0, 9))
            0:       v = {32'd0, lim};
            1:       v = {32'd0, lim} + 64'd1;
            2:       v = (lim == 0) ? 64'd0 : {32'd0, lim} - 64'd1;
            3:       v = {32'd0, $urandom};
            4:       v = {$urandom, $urandom} % 64'd1000000000000;
            default: v = {32'd0, $urandom_range(0, 999)};
        endcase
        if ($urandom_range(0, 7) == 0)
            word.push_back("0");
        push_text($sformatf("%0d", v));
    endfunction

    function automatic void make_raw();
        int fmax;
        fmax = int'(lim_fraction);
        if ($urandom_range(0, 3) == 0)
            word.push_back(CHAR_PLUS);
        push_amount(lim_seconds);
        if ($urandom_range(0, 2) != 0) begin
            word.push_back(CHAR_POINT);
            repeat ($urandom_range(0, fmax + 1))
                word.push_back(8'("0" + $urandom_range(0, 9)));
        end
    endfunction

    // Mostly decreasing unit chains; an occasional random unit or letter breaks order.
    function automatic void make_tokens();
        int         n, tmax, code;
        logic [7:0] letter;
        tmax = int'(lim_tokens);
        n    = $urandom_range(1, tmax + 1);
        code = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0)
            word.push_back(CHAR_PLUS);
        repeat (n) begin
            push_amount(lim_amount);
            case (code)
                UNIT_YEAR:           letter = "y";
                UNIT_MONTH, UNIT_MIN: letter = "m";
                UNIT_DAY:            letter = "d";
                UNIT_HOUR:           letter = "h";
                UNIT_SEC:            letter = "s";
                default:             letter = "u";
            endcase
            if ($urandom_range(0, 15) == 0)
                letter = 8'("a" + $urandom_range(0, 25));
            if ($urandom_range(0, 1) == 1)
                letter = letter - 8'd32;
            word.push_back(letter);
            if (code == UNIT_MONTH)
                code = UNIT_DAY;
            else if (code > 0 && $urandom_range(0, 7) != 0)
                code = $urandom_range(0, code - 1);
            else
                code = $urandom_range(0, 6);
        end
    endfunction

    function automatic void make_noise();
        string pool;
        pool = "+.0123456789ydhmsuYDHMSUx";
        repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 1) == 1)
                word.push_back(8'($urandom_range(0, 255)));
            else
                word.push_back(pool[$urandom_range(0, pool.len() - 1)]);
        end
    endfunction

    function automatic void make_string();
        int pick, pos;
        pick = $urandom_range(0, 19);
        if (pick < 8) begin
            make_tokens();
        end else if (pick < 14) begin
            make_raw();
        end else if (pick < 17) begin
            if (pick == 14) make_raw(); else make_tokens();
            pos = $urandom_range(0, word.size() - 1);
            if ($urandom_range(0, 1) == 1)
                word[pos] = 8'($urandom_range(0, 255));
            else
                word.delete(pos);
        end else begin
            make_noise();
        end
    endfunction

    task automatic send_item(input logic [7:0] c, input bit eos, input bit typed,
                             input verdict_t want);
        verdict_t v;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eos;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        accepted++;
        if (scan_char(c, eos, v))
            pending_verdicts.push_back(typed ? want : v);
    endtask

    task automatic send_word(input bit typed, input verdict_t want);
        foreach (word[i])
            send_item(word[i], 1'b0, 1'b0, '0);
        send_item(8'($urandom_range(0, 255)), 1'b1, typed, want);
        word.delete();
    endtask

    // Wait until every verdict is back and the pipeline has emptied.
    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_limits(input logic [31:0] secs, input logic [31:0] amt,
                                input logic [3:0] frac, input logic [2:0] toks);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_SECONDS_LIMIT;
        cfg_data  <= secs;
        @(posedge aclk);
        cfg_index <= CFG_AMOUNT_LIMIT;
        cfg_data  <= amt;
        @(posedge aclk);
        cfg_index <= CFG_FRACTION_LIMIT;
        cfg_data  <= {28'd0, frac};
        @(posedge aclk);
        cfg_index <= CFG_TOKEN_LIMIT;
        cfg_data  <= {29'd0, toks};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        lim_seconds  = secs;
        lim_amount   = amt;
        lim_fraction = frac;
        lim_tokens   = toks;
    endtask

    function automatic void add_probe(input string text, input bit typed, input logic ok,
                                      input logic [1:0] form, input logic plus);
        probe_text.push_back(text);
        probe_typed.push_back(typed);
        probe_want.push_back({ok, form, plus});
    endfunction

    // Receiver: stretches of always-ready, coin-flip and mostly-stalled.
    always @(posedge aclk) begin
        if (ready_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            ready_left = $urandom_range(16, 96);
        end
        ready_left--;
        case (ready_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge aclk) begin : check_result
        verdict_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[0], m_tuser, m_tdata[1]};
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected result transaction valid=%0b form=%0d plus=%0b",
                         $time, got.ok, got.form, got.plus);
                mismatches++;
            end else begin
                want = pending_verdicts.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch: expected valid=%0b form=%0d plus=%0b,",
                             $time, want.ok, want.form, want.plus,
                             " got valid=%0b form=%0d plus=%0b",
                             got.ok, got.form, got.plus);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        int goal;
        lim_seconds  = 32'd2147483647;
        lim_amount   = 32'd2147483647;
        lim_fraction = 4'd6;
        lim_tokens   = 3'd7;
        clear_scan();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed strings under tight limits: seconds 9, amount 9, one fraction digit,
        // two tokens.
        add_probe("",      1'b1, 1'b0, FORM_NONE, 1'b0);
        add_probe("+",     1'b1, 1'b0, FORM_NONE, 1'b1);
        add_probe("9",     1'b1, 1'b1, FORM_RAW,  1'b0);
        add_probe("10",    1'b1, 1'b0, FORM_NONE, 1'b0);
        add_probe("1.23",  1'b1, 1'b0, FORM_NONE, 1'b0);
        add_probe("2m1D",  1'b0, 1'b0, FORM_NONE, 1'b0);
        add_probe("1s2h",  1'b1, 1'b0, FORM_NONE, 1'b0);
        add_probe("1h2s3", 1'b1, 1'b0, FORM_NONE, 1'b0);
        add_probe("++",    1'b1, 1'b0, FORM_NONE, 1'b1);
        add_probe("\200",  1'b1, 1'b0, FORM_NONE, 1'b0);
        write_limits(32'd9, 32'd9, 4'd1, 3'd2);
        foreach (probe_text[i]) begin
            push_text(probe_text[i]);
            send_word(probe_typed[i], probe_want[i]);
        end

        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0: write_limits(32'hFFFFFFFF, 32'hFFFFFFFF, 4'd9, 3'd7);
                1: write_limits(32'd0, 32'd0, 4'd0, 3'd0);
                2: write_limits(32'd9, 32'd9, 4'd1, 3'd1);
                3: write_limits(32'd1000, 32'd59, 4'd15, 3'd3);
                4: write_limits($urandom, $urandom, 4'($urandom_range(0, 15)),
                                3'($urandom_range(0, 7)));
                5: write_limits(32'd2147483647, 32'd2147483647, 4'd6, 3'd7);
                default: write_limits($urandom_range(10, 100000), 32'hFFFFFFFE, 4'd5, 3'd6);
            endcase
            goal = accepted + 250;
            while (accepted < goal) begin
                make_string();
                send_word(1'b0, '0);
            end
        end

        settle();
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
